// ===== rtl/rtn_pkg.sv =====
package rtn_pkg;

    localparam int ACC_WIDTH_DEF = 16;
    localparam int DIV_W         = 32;
    localparam int DIV_CNT_W     = 6;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] VAR_D    = 8'h64;
    localparam logic [7:0] VAR_O    = 8'h6F;
    localparam logic [7:0] VAR_B    = 8'h62;

    localparam logic [15:0] LEN_RESET   = 16'd4;
    localparam logic [3:0]  OCT_RESET   = 4'd6;
    localparam logic [15:0] WHOLE_RESET = 16'd952;
    localparam logic [3:0]  OCT_MAX     = 4'd10;
    localparam logic [15:0] MINUTE_MS   = 16'd60000;

    typedef enum logic [1:0] {
        PH_NAME,
        PH_DEFS,
        PH_NOTES
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BDIV,
        ST_NDIV,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SEG_ON,
        ST_SEG_END
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    // Octave-0 note frequency, Hz scaled by 2^16
    function automatic logic [31:0] octave0_freq(input logic [3:0] pitch);
        logic [31:0] f;
        case (pitch)
            4'd0:    f = 32'd1071618;
            4'd1:    f = 32'd1135340;
            4'd2:    f = 32'd1202851;
            4'd3:    f = 32'd1274376;
            4'd4:    f = 32'd1350154;
            4'd5:    f = 32'd1430439;
            4'd6:    f = 32'd1515497;
            4'd7:    f = 32'd1605613;
            4'd8:    f = 32'd1701088;
            4'd9:    f = 32'd1802240;
            4'd10:   f = 32'd1909407;
            4'd11:   f = 32'd2022946;
            default: f = 32'd0;
        endcase
        return f;
    endfunction

endpackage

// ===== rtl/rtn_div.sv =====
module rtn_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  rtn_pkg::div_req_t req,
    output rtn_pkg::div_rsp_t rsp
);

    localparam int W = rtn_pkg::DIV_W;

    logic [W-1:0]                   rem_reg, rem_next;
    logic [W-1:0]                   quo_reg, quo_next;
    logic [W-1:0]                   den_reg, den_next;
    logic [rtn_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [W:0]                     trial;

    // One restoring step a cycle, most significant bit first
    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[W-1]};
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            den_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == rtn_pkg::DIV_CNT_W'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/ringtone_text_to_tone_commands.sv =====
// Ringtone text to tone segments.
// Slave channel s_*: one text character per transaction, s_tlast marks the
// final byte of a song. Master channel m_*: one tone segment per transaction,
// m_tlast marks the final segment caused by that byte.
// cfg_wr_en/cfg_wr_data write the rate scale word; write only while idle.
// A byte that ends no note keeps the block idle, ready for the next byte,
// unless it stores a b= value. A byte that ends a note runs the shared
// restoring divider (note length), then the low and high 32x16 partial
// products for the rate word; the next byte is taken once its segments
// are accepted. A zero note length skips the divider. A nonzero b= value
// stored in the header costs one divider pass before the next byte is taken.
// s_tready is low while a byte is at work or its segments wait; a stalled
// receiver holds the output register and with it the whole block.
// Reset (aresetn low, synchronous) returns to skipping the song name with
// defaults length 4, octave 6 and 952 ms per whole note, and clears the
// rate scale.
module ringtone_text_to_tone_commands #(
    parameter int ACC_WIDTH = rtn_pkg::ACC_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] segment_ms, [47:16] tone_rate
    output logic        m_tlast    // run_last
);

    localparam logic [ACC_WIDTH-1:0] ACC_MAX = '1;

    rtn_pkg::state_t         state_reg, state_next;
    rtn_pkg::phase_t         phase_reg, phase_next;
    logic [31:0]             scale_reg;
    logic [15:0]             dlen_reg, dlen_next;
    logic [3:0]              doct_reg, doct_next;
    logic [15:0]             whole_reg, whole_next;
    logic [ACC_WIDTH-1:0]    acc_reg, acc_next;
    logic [1:0]              fpos_reg, fpos_next;
    logic [7:0]              var_reg, var_next;
    logic signed [4:0]       pitch_reg, pitch_next;
    logic                    dot_reg, dot_next;
    logic [15:0]             nlen_reg, nlen_next;
    logic [31:0]             freq_reg, freq_next;
    logic [15:0]             ms_reg, ms_next;
    logic [63:0]             prod_reg, prod_next;
    logic                    mv_reg, mv_next;
    logic [47:0]             md_reg, md_next;
    logic                    ml_reg, ml_next;
    rtn_pkg::div_req_t       div_req;
    rtn_pkg::div_rsp_t       div_rsp;

    logic                    accept;
    logic [7:0]              ch;
    logic                    is_digit;
    logic [ACC_WIDTH+3:0]    acc_x10;
    logic [ACC_WIDTH-1:0]    acc_dig;
    logic [31:0]             acc32;
    logic [15:0]             acc_c16;
    logic [3:0]              acc_oct;
    logic                    is_letter;
    logic signed [4:0]       letter_p;
    logic                    finish;
    logic [3:0]              fin_oct;
    logic [17:0]             fin_num;
    logic [15:0]             gap;

    rtn_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign accept = s_tvalid && s_tready;
    assign ch     = s_tdata;

    // Decimal accumulate with saturation, clamps of the running number
    always_comb begin
        is_digit = (ch >= rtn_pkg::CH_ZERO) && (ch <= rtn_pkg::CH_NINE);
        acc_x10  = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0}
                 + (ACC_WIDTH+4)'(ch - rtn_pkg::CH_ZERO);
        acc_dig  = (acc_x10 > (ACC_WIDTH+4)'(ACC_MAX)) ? ACC_MAX : acc_x10[ACC_WIDTH-1:0];
        acc32    = 32'(acc_reg);
        acc_c16  = (acc32 > 32'd65535) ? 16'hFFFF : acc32[15:0];
        acc_oct  = (acc32 > 32'(rtn_pkg::OCT_MAX)) ? rtn_pkg::OCT_MAX : acc32[3:0];
    end

    // Note letter decode, case folded
    always_comb begin
        is_letter = 1'b1;
        letter_p  = 5'sd0;
        unique case (ch | 8'h20)
            8'h63:   letter_p = 5'sd0;
            8'h64:   letter_p = 5'sd2;
            8'h65:   letter_p = 5'sd4;
            8'h66:   letter_p = 5'sd5;
            8'h67:   letter_p = 5'sd7;
            8'h61:   letter_p = 5'sd9;
            8'h62:   letter_p = 5'sd11;
            8'h68:   letter_p = 5'sd11;
            8'h70:   letter_p = -5'sd1;
            default: is_letter = 1'b0;
        endcase
    end

    // Parser, sequencer and output register
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        dlen_next  = dlen_reg;
        doct_next  = doct_reg;
        whole_next = whole_reg;
        acc_next   = acc_reg;
        fpos_next  = fpos_reg;
        var_next   = var_reg;
        pitch_next = pitch_reg;
        dot_next   = dot_reg;
        nlen_next  = nlen_reg;
        freq_next  = freq_reg;
        ms_next    = ms_reg;
        prod_next  = prod_reg;
        mv_next    = mv_reg;
        md_next    = md_reg;
        ml_next    = ml_reg;
        finish     = 1'b0;
        fin_oct    = doct_reg;
        fin_num    = '0;
        gap        = ms_reg >> 4;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        s_tready   = (state_reg == rtn_pkg::ST_IDLE);

        unique case (state_reg)
            rtn_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (phase_reg)
                        rtn_pkg::PH_NAME: begin
                            if (ch == rtn_pkg::CH_COLON) begin
                                dlen_next  = rtn_pkg::LEN_RESET;
                                doct_next  = rtn_pkg::OCT_RESET;
                                whole_next = rtn_pkg::WHOLE_RESET;
                                acc_next   = '0;
                                fpos_next  = '0;
                                var_next   = '0;
                                phase_next = rtn_pkg::PH_DEFS;
                            end
                        end
                        rtn_pkg::PH_DEFS: begin
                            if (ch == rtn_pkg::CH_COMMA || ch == rtn_pkg::CH_COLON) begin
                                if (var_reg == rtn_pkg::VAR_D) dlen_next = acc_c16;
                                if (var_reg == rtn_pkg::VAR_O) doct_next = acc_oct;
                                if (var_reg == rtn_pkg::VAR_B) begin
                                    if (acc_reg == '0) begin
                                        whole_next = 16'hFFFF;
                                    end else begin
                                        div_req.start    = 1'b1;
                                        div_req.dividend = 32'(rtn_pkg::MINUTE_MS);
                                        div_req.divisor  = acc32;
                                        state_next       = rtn_pkg::ST_BDIV;
                                    end
                                end
                                acc_next  = '0;
                                fpos_next = '0;
                                if (ch == rtn_pkg::CH_COLON) begin
                                    phase_next = rtn_pkg::PH_NOTES;
                                    pitch_next = -5'sd1;
                                    dot_next   = 1'b0;
                                    nlen_next  = (var_reg == rtn_pkg::VAR_D) ? acc_c16 : dlen_reg;
                                end
                            end else if (ch != rtn_pkg::CH_SPACE && ch != rtn_pkg::CH_TAB) begin
                                if (fpos_reg < 2'd2) fpos_next = fpos_reg + 2'd1;
                                if (fpos_reg == 2'd0) var_next = ch;
                                else if (is_digit) acc_next = acc_dig;
                            end
                        end
                        default: begin
                            if (ch == rtn_pkg::CH_COMMA) begin
                                finish = 1'b1;
                            end else begin
                                if (is_digit) begin
                                    acc_next = acc_dig;
                                end else if (ch == rtn_pkg::CH_HASH) begin
                                    if (pitch_reg < 5'sd15) pitch_next = pitch_reg + 5'sd1;
                                end else if (ch == rtn_pkg::CH_DOT) begin
                                    dot_next = 1'b1;
                                end else if (is_letter) begin
                                    pitch_next = letter_p;
                                    if (acc_reg != '0) nlen_next = acc_c16;
                                    acc_next = '0;
                                end
                                finish = s_tlast;
                            end
                        end
                    endcase

                    // Finish the note with its updated fields, then clear it
                    if (finish) begin
                        if (acc_next != '0) begin
                            fin_oct = (32'(acc_next) > 32'(rtn_pkg::OCT_MAX))
                                    ? rtn_pkg::OCT_MAX : acc_next[3:0];
                        end
                        if (pitch_next >= 5'sd0 && pitch_next <= 5'sd11)
                            freq_next = rtn_pkg::octave0_freq(pitch_next[3:0]) << fin_oct;
                        else
                            freq_next = '0;
                        fin_num = dot_next ? (18'(whole_reg) * 18'd3) : {1'b0, whole_reg, 1'b0};
                        if (nlen_next == '0) begin
                            ms_next    = 16'hFFFF;
                            state_next = rtn_pkg::ST_MUL_LO;
                        end else begin
                            div_req.start    = 1'b1;
                            div_req.dividend = 32'(fin_num);
                            div_req.divisor  = 32'({nlen_next, 1'b0});
                            state_next       = rtn_pkg::ST_NDIV;
                        end
                        pitch_next = -5'sd1;
                        dot_next   = 1'b0;
                        nlen_next  = dlen_reg;
                        acc_next   = '0;
                    end
                    if (s_tlast) phase_next = rtn_pkg::PH_NAME;
                end
            end
            rtn_pkg::ST_BDIV: begin
                if (div_rsp.done) begin
                    whole_next = div_rsp.quotient[15:0];
                    state_next = rtn_pkg::ST_IDLE;
                end
            end
            rtn_pkg::ST_NDIV: begin
                if (div_rsp.done) begin
                    ms_next    = div_rsp.quotient[15:0];
                    state_next = rtn_pkg::ST_MUL_LO;
                end
            end
            rtn_pkg::ST_MUL_LO: begin
                prod_next  = 64'(scale_reg * 48'(freq_reg[15:0])) + 64'h8000_0000;
                state_next = rtn_pkg::ST_MUL_HI;
            end
            rtn_pkg::ST_MUL_HI: begin
                prod_next  = prod_reg
                           + ({16'(0), 48'(scale_reg * 48'(freq_reg[31:16]))} << 16);
                state_next = rtn_pkg::ST_SEG_ON;
            end
            rtn_pkg::ST_SEG_ON: begin
                if (!mv_reg) begin
                    mv_next = 1'b1;
                    if (freq_reg != '0) begin
                        md_next = {prod_reg[63:32], ms_reg - gap};
                        ml_next = 1'b0;
                    end else begin
                        md_next = {32'd0, ms_reg};
                        ml_next = 1'b1;
                    end
                end else if (m_tready) begin
                    if (!ml_reg) begin
                        md_next    = {32'd0, gap};
                        ml_next    = 1'b1;
                        state_next = rtn_pkg::ST_SEG_END;
                    end else begin
                        mv_next    = 1'b0;
                        state_next = rtn_pkg::ST_IDLE;
                    end
                end
            end
            rtn_pkg::ST_SEG_END: begin
                if (m_tready) begin
                    mv_next    = 1'b0;
                    state_next = rtn_pkg::ST_IDLE;
                end
            end
            default: state_next = rtn_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rtn_pkg::ST_IDLE;
            phase_reg <= rtn_pkg::PH_NAME;
            scale_reg <= '0;
            dlen_reg  <= rtn_pkg::LEN_RESET;
            doct_reg  <= rtn_pkg::OCT_RESET;
            whole_reg <= rtn_pkg::WHOLE_RESET;
            acc_reg   <= '0;
            fpos_reg  <= '0;
            var_reg   <= '0;
            pitch_reg <= -5'sd1;
            dot_reg   <= 1'b0;
            nlen_reg  <= rtn_pkg::LEN_RESET;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            if (cfg_wr_en) scale_reg <= cfg_wr_data;
            dlen_reg  <= dlen_next;
            doct_reg  <= doct_next;
            whole_reg <= whole_next;
            acc_reg   <= acc_next;
            fpos_reg  <= fpos_next;
            var_reg   <= var_next;
            pitch_reg <= pitch_next;
            dot_reg   <= dot_next;
            nlen_reg  <= nlen_next;
            mv_reg    <= mv_next;
        end
        freq_reg <= freq_next;
        ms_reg   <= ms_next;
        prod_reg <= prod_next;
        md_reg   <= md_next;
        ml_reg   <= ml_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;

endmodule
